// File: rtl/core/ecc_pkg.sv
// ecc_pkg: shared types, character codes and helpers for the extended cigar converter
// no dependencies; used by every file in rtl/core
package ecc_pkg;

	localparam int COUNT_BITS = 32;
	localparam int RUN_BITS   = 32;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [COUNT_BITS+3:0] count_wide_t;
	typedef logic [2:0]            op_t;
	typedef logic [6:0]            char_t;

	localparam op_t OP_M    = 3'd0;
	localparam op_t OP_I    = 3'd1;
	localparam op_t OP_D    = 3'd2;
	localparam op_t OP_N    = 3'd3;
	localparam op_t OP_S    = 3'd4;
	localparam op_t OP_H    = 3'd5;
	localparam op_t OP_NONE = 3'd6;

	localparam char_t CH_0     = 7'h30;
	localparam char_t CH_9     = 7'h39;
	localparam char_t CH_LPAR  = 7'h28;
	localparam char_t CH_RPAR  = 7'h29;
	localparam char_t CH_LBRK  = 7'h5B;
	localparam char_t CH_RBRK  = 7'h5D;
	localparam char_t CH_A     = 7'h41;
	localparam char_t CH_C     = 7'h43;
	localparam char_t CH_G     = 7'h47;
	localparam char_t CH_T     = 7'h54;
	localparam char_t CH_N     = 7'h4E;
	localparam char_t CH_EQ    = 7'h3D;
	localparam char_t CH_PLUS  = 7'h2B;
	localparam char_t CH_MINUS = 7'h2D;
	localparam char_t CH_STAR  = 7'h2A;
	localparam char_t CH_PCT   = 7'h25;
	localparam char_t CH_SLASH = 7'h2F;

	localparam count_t COUNT_MAX = '1;

	typedef struct packed {
		logic [6:0] symbol;
		logic       final_symbol;
	} sym_word_t;

	typedef struct packed {
		logic [RUN_BITS-1:0] run_length;
		op_t                 op_code;
		logic                bad_symbol;
		logic                string_done;
	} tok_word_t;

	typedef struct packed {
		count_t    pend_next;
		count_t    match_next;
		tok_word_t tok0;
		tok_word_t tok1;
		logic [1:0] tok_cnt;
	} gen_out_t;

	function automatic count_t sat_add(input count_t a, input count_t b);
		logic [COUNT_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
	endfunction

	function automatic op_t map_op(input char_t c);
		op_t r;
		case (c)
			CH_PLUS:                    r = OP_I;
			CH_MINUS:                   r = OP_D;
			CH_STAR, CH_PCT, CH_SLASH:  r = OP_N;
			CH_RPAR:                    r = OP_S;
			CH_RBRK:                    r = OP_H;
			default:                    r = OP_NONE;
		endcase
		return r;
	endfunction

	function automatic tok_word_t make_tok(input count_t len, input op_t op, input logic bad);
		tok_word_t t;
		t.run_length  = RUN_BITS'(len);
		t.op_code     = op;
		t.bad_symbol  = bad;
		t.string_done = 1'b0;
		return t;
	endfunction

endpackage

// File: rtl/core/ecc_token_gen.sv
// ecc_token_gen: decodes one character against the running counts into up to two tokens
// depends on ecc_pkg
module ecc_token_gen (
	input  ecc_pkg::sym_word_t sym,
	input  ecc_pkg::count_t    pend,
	input  ecc_pkg::count_t    match,
	output ecc_pkg::gen_out_t  gen
);

	ecc_pkg::count_wide_t ext;
	ecc_pkg::count_wide_t prod;

	always_comb begin
		ext  = ecc_pkg::count_wide_t'(pend);
		// low nibble of an ascii digit is its value
		prod = (ext << 3) + (ext << 1) + ecc_pkg::count_wide_t'(sym.symbol[3:0]);
	end

	always_comb begin
		gen.pend_next  = pend;
		gen.match_next = match;
		gen.tok0       = '0;
		gen.tok1       = '0;
		gen.tok_cnt    = 2'd0;

		case (sym.symbol) inside
			[ecc_pkg::CH_0:ecc_pkg::CH_9]: begin
				if (prod > ecc_pkg::count_wide_t'(ecc_pkg::COUNT_MAX))
					gen.pend_next = ecc_pkg::COUNT_MAX;
				else
					gen.pend_next = prod[ecc_pkg::COUNT_BITS-1:0];
			end
			ecc_pkg::CH_LPAR, ecc_pkg::CH_LBRK: begin
			end
			ecc_pkg::CH_A, ecc_pkg::CH_C, ecc_pkg::CH_G, ecc_pkg::CH_T, ecc_pkg::CH_N: begin
				gen.match_next = ecc_pkg::sat_add(match, ecc_pkg::count_t'(1));
			end
			ecc_pkg::CH_EQ: begin
				gen.match_next = ecc_pkg::sat_add(match, pend);
				gen.pend_next  = '0;
			end
			ecc_pkg::CH_PLUS, ecc_pkg::CH_MINUS, ecc_pkg::CH_STAR, ecc_pkg::CH_PCT,
			ecc_pkg::CH_SLASH, ecc_pkg::CH_RPAR, ecc_pkg::CH_RBRK: begin
				// flush pending matches ahead of the operation
				if (match != '0) begin
					gen.tok0    = ecc_pkg::make_tok(match, ecc_pkg::OP_M, 1'b0);
					gen.tok1    = ecc_pkg::make_tok(pend, ecc_pkg::map_op(sym.symbol), 1'b0);
					gen.tok_cnt = 2'd2;
				end else begin
					gen.tok0    = ecc_pkg::make_tok(pend, ecc_pkg::map_op(sym.symbol), 1'b0);
					gen.tok_cnt = 2'd1;
				end
				gen.pend_next  = '0;
				gen.match_next = '0;
			end
			default: begin
				gen.tok0       = ecc_pkg::make_tok('0, ecc_pkg::OP_NONE, 1'b1);
				gen.tok_cnt    = 2'd1;
				gen.pend_next  = '0;
				gen.match_next = '0;
			end
		endcase

		if (sym.final_symbol) begin
			if (gen.match_next != '0) begin
				if (gen.tok_cnt == 2'd0) begin
					gen.tok0    = ecc_pkg::make_tok(gen.match_next, ecc_pkg::OP_M, 1'b0);
					gen.tok_cnt = 2'd1;
				end else begin
					gen.tok1    = ecc_pkg::make_tok(gen.match_next, ecc_pkg::OP_M, 1'b0);
					gen.tok_cnt = 2'd2;
				end
			end else if (gen.tok_cnt == 2'd0) begin
				gen.tok0    = ecc_pkg::make_tok('0, ecc_pkg::OP_NONE, 1'b0);
				gen.tok_cnt = 2'd1;
			end
			if (gen.tok_cnt == 2'd2)
				gen.tok1.string_done = 1'b1;
			else
				gen.tok0.string_done = 1'b1;
			gen.pend_next  = '0;
			gen.match_next = '0;
		end
	end

endmodule

// File: rtl/core/extended_cigar_to_cigar_converter.sv
// extended_cigar_to_cigar_converter: top level, input register, count state, output buffer
// depends on ecc_pkg and ecc_token_gen
//
// usage:
// in channel (in_valid/in_ready/in_data) takes one character word per cycle while in_ready is high:
// an ascii symbol and a flag marking the last character of a cigar string.
// out channel (out_valid/out_ready/out_data) gives sam cigar tokens:
// run length, operation code, bad symbol flag and end-of-string flag.
// a character gives zero, one or two tokens, in string order.
// an accepted character word waits in the input register, is decoded there and
// its tokens go into the two-entry output buffer that drives out_data.
// throughput: one character per cycle while the receiver keeps up and no
// character gives two tokens; a two-token character fills the two-entry
// buffer, which the single output port drains one token at a time.
// reset clears the pending count, the match total, the input register valid
// flag and the output buffer count; the first word after reset starts a fresh string.
// when the receiver stalls, the buffer holds its words and in_ready drops
// once the input register holds a word that no longer fits.
module extended_cigar_to_cigar_converter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ecc_pkg::sym_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ecc_pkg::tok_word_t  out_data
);

	logic               valid_s1;
	ecc_pkg::sym_word_t sym_s1;
	ecc_pkg::count_t    pend_q;
	ecc_pkg::count_t    match_q;
	ecc_pkg::tok_word_t buf_q [2];
	logic [1:0]         cnt_q;

	ecc_pkg::gen_out_t  gen;
	ecc_pkg::tok_word_t head;
	ecc_pkg::tok_word_t nb0;
	ecc_pkg::tok_word_t nb1;
	logic [1:0]         rem;
	logic [1:0]         ncnt;
	logic               pop;
	logic               consume;

	ecc_token_gen u_gen (
		.sym   (sym_s1),
		.pend  (pend_q),
		.match (match_q),
		.gen   (gen)
	);

	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = buf_q[0];
	assign pop       = out_valid && out_ready;
	assign in_ready  = !valid_s1 || consume;

	always_comb begin
		if (pop) begin
			head = buf_q[1];
			rem  = cnt_q - 2'd1;
		end else begin
			head = buf_q[0];
			rem  = cnt_q;
		end
		consume = valid_s1 && (gen.tok_cnt <= (2'd2 - rem));
		nb0  = head;
		nb1  = buf_q[1];
		ncnt = rem;
		if (consume) begin
			ncnt = rem + gen.tok_cnt;
			case (rem)
				2'd0: begin
					nb0 = gen.tok0;
					nb1 = gen.tok1;
				end
				2'd1: begin
					nb1 = gen.tok0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pend_q   <= '0;
			match_q  <= '0;
			cnt_q    <= 2'd0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (consume) begin
				pend_q  <= gen.pend_next;
				match_q <= gen.match_next;
			end
			cnt_q <= ncnt;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			sym_s1 <= in_data;
		buf_q[0] <= nb0;
		buf_q[1] <= nb1;
	end

endmodule

// File: rtl/core/ecc_checker.sv
// ecc_checker: port-level checks on the converter output channel, bound to the top level
// depends on ecc_pkg and extended_cigar_to_cigar_converter
module ecc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input ecc_pkg::tok_word_t out_data
);

	// stalled word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word dropped or changed under stall");

	// error token shape
	a_bad_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.bad_symbol |->
			out_data.op_code == ecc_pkg::OP_NONE && out_data.run_length == '0)
		else $error("bad symbol token malformed");

	// end token shape
	a_none_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.op_code == ecc_pkg::OP_NONE && !out_data.bad_symbol |->
			out_data.string_done && out_data.run_length == '0)
		else $error("end token malformed");

	// an idle input followed by an empty output keeps the output empty
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ready && !in_valid) ##1 (!out_valid) |=> !out_valid)
		else $error("token appeared without input");

endmodule

bind extended_cigar_to_cigar_converter ecc_checker u_ecc_checker (.*);
